[hdl/dirty_page_table_top_macros.svh]
// ----------------------------------------------------------------------------
// Dirty page table assertion macros
// Shared property forms for the checks in the dirty page table top level.
// ----------------------------------------------------------------------------
`ifndef DIRTY_PAGE_TABLE_TOP_MACROS_SVH
`define DIRTY_PAGE_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dpt_pkg.sv]
// ----------------------------------------------------------------------------
// Dirty page table package
// Table size, derived widths, operation codes and transaction types.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int TableEntries = 1024;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  typedef enum logic [1:0] {
    OpAdd      = 2'd0,
    OpRemove   = 2'd1,
    OpContains = 2'd2,
    OpNext     = 2'd3
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [31:0] page_id;
    logic [31:0] rec_lsn;
    logic [9:0]  scan_start;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  found_index;
    logic [31:0] entry_page;
    logic [31:0] entry_lsn;
    logic [10:0] dirty_count;
  } result_t;

  typedef struct packed {
    logic        occ;
    logic [31:0] page;
    logic [31:0] lsn;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

[hdl/dirty_page_table_top.sv]
// ----------------------------------------------------------------------------
// Dirty page table top level
// Direct-mapped table of dirty pages with add, remove, contains and scan.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table clear, one bucket per cycle, and
// holds busy_o high until the last bucket is cleared. A transaction is taken
// when start_i is high and busy_o is low. Add, remove and contains read their
// bucket through the one read port of the bucket store as they are taken; add
// and remove write it back through the one write port from the run state.
// Their result appears on the next cycle, when a new transaction may already
// be taken. A scan reads one bucket per cycle through the same read port, from
// scan_start until it finds an occupied bucket or reaches the last one.
// Each result is shown for exactly one cycle with result_valid_o high and
// must be captured then; the receiver cannot hold it off.

`include "dirty_page_table_top_macros.svh"

module dirty_page_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dpt_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output dpt_pkg::result_t result_o
);

  dpt_pkg::mem_req_t mem_req;
  dpt_pkg::entry_t   rd_data;

  dpt_table u_table (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  dpt_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .mem_req_o      (mem_req),
    .rd_data_i      (rd_data)
  );

  `DPT_ASSERT_NEXT(a_accept_busy, start_i && !busy_o,
      busy_o && !result_valid_o,
      "Accepted transaction did not make the block busy.")
  `DPT_ASSERT_SAME(a_count_range, result_valid_o,
      32'(result_o.dirty_count) <= dpt_pkg::TableEntries,
      "Dirty count exceeds the table size.")
  `DPT_ASSERT_SAME(a_miss_empty, result_valid_o && !result_o.found,
      result_o.entry_page == '0 && result_o.entry_lsn == '0,
      "Result without a hit carries entry data.")
  `DPT_ASSERT_SAME(a_result_idle, result_valid_o, !busy_o,
      "Result strobe while the sequencer is still busy.")

endmodule

[hdl/dpt_table.sv]
// ----------------------------------------------------------------------------
// Dirty page table bucket store
// One bucket per entry, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dpt_table (
  input  logic             clk_i,
  input  dpt_pkg::mem_req_t req_i,
  output dpt_pkg::entry_t  rd_data_o
);

  dpt_pkg::entry_t mem_q [dpt_pkg::TableEntries];
  dpt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/dpt_seq.sv]
// ----------------------------------------------------------------------------
// Dirty page table sequencer
// Clears the store after reset, runs add and remove as a read-modify-write
// and walks the buckets with one shared index incrementer for the scan.
// ----------------------------------------------------------------------------
module dpt_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dpt_pkg::item_t    item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output dpt_pkg::result_t  result_o,
  output dpt_pkg::mem_req_t mem_req_o,
  input  dpt_pkg::entry_t   rd_data_i
);

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StRun   = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [dpt_pkg::IdxW-1:0]  cur_q, cur_d;
  logic [dpt_pkg::IdxW-1:0]  cur_inc;
  logic [dpt_pkg::CntW-1:0]  count_q, count_d;
  dpt_pkg::item_t            cmd_q, cmd_d;
  logic                      oor_q, oor_d;
  logic                      res_vld_q, res_vld_d;
  dpt_pkg::result_t          res_q, res_d;
  logic                      finish;
  logic                      hit;
  logic [dpt_pkg::IdxW-1:0]  rep_idx;

  assign cur_inc = cur_q + dpt_pkg::IdxW'(1);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    oor_d     = oor_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    finish    = 1'b0;
    hit       = 1'b0;
    rep_idx   = cur_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = cur_q;
    mem_req_o.wdata = '0;
    mem_req_o.raddr = cur_inc;

    unique case (state_q)
      StClear: begin
        mem_req_o.we = 1'b1;
        cur_d = cur_inc;
        if (cur_q == dpt_pkg::LastIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (item_i.operation == dpt_pkg::OpNext) begin
          mem_req_o.raddr = dpt_pkg::IdxW'(item_i.scan_start);
        end else begin
          mem_req_o.raddr = item_i.page_id[dpt_pkg::IdxW-1:0];
        end
        if (start_i) begin
          cmd_d   = item_i;
          oor_d   = 32'(item_i.scan_start) >= dpt_pkg::TableEntries;
          cur_d   = mem_req_o.raddr;
          state_d = StRun;
        end
      end
      StRun: begin
        case (cmd_q.operation)
          dpt_pkg::OpAdd: begin
            finish = 1'b1;
            if (cmd_q.rec_lsn != '0 && !rd_data_i.occ) begin
              mem_req_o.we         = 1'b1;
              mem_req_o.wdata.occ  = 1'b1;
              mem_req_o.wdata.page = cmd_q.page_id;
              mem_req_o.wdata.lsn  = cmd_q.rec_lsn;
              count_d = count_q + dpt_pkg::CntW'(1);
            end
          end
          dpt_pkg::OpRemove: begin
            finish = 1'b1;
            if (rd_data_i.occ) begin
              mem_req_o.we = 1'b1;
              count_d = count_q - dpt_pkg::CntW'(1);
            end
          end
          dpt_pkg::OpContains: begin
            finish = 1'b1;
            hit    = rd_data_i.occ;
          end
          default: begin
            if (oor_q) begin
              finish  = 1'b1;
              rep_idx = '0;
            end else if (rd_data_i.occ) begin
              finish = 1'b1;
              hit    = 1'b1;
            end else if (cur_q == dpt_pkg::LastIdx) begin
              finish  = 1'b1;
              rep_idx = '0;
            end else begin
              cur_d = cur_inc;
            end
          end
        endcase
        if (finish) begin
          state_d           = StIdle;
          res_vld_d         = 1'b1;
          res_d.found       = hit;
          res_d.found_index = 10'(rep_idx);
          res_d.entry_page  = hit ? rd_data_i.page : '0;
          res_d.entry_lsn   = hit ? rd_data_i.lsn : '0;
          res_d.dirty_count = 11'(count_d);
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      cur_q     <= '0;
      count_q   <= '0;
      oor_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      count_q   <= count_d;
      oor_q     <= oor_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy_o         = state_q != StIdle;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule
